FILE: sv/debug_packet_deframer_unit_defines.svh
// Assertion macros shared by the deframer modules.
// Define NO_ASSERTIONS to compile every check away.
`ifndef DEBUG_PACKET_DEFRAMER_UNIT_DEFINES_SVH
`define DEBUG_PACKET_DEFRAMER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Checks that a property holds at every clock edge outside reset.
`define DPD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that a condition never occurs outside reset.
`define DPD_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define DPD_ASSERT(lbl, clk, rst, prop, msg)
`define DPD_ASSERT_NEVER(lbl, clk, rst, cond, msg)

`endif

`endif

FILE: sv/dpd_pkg.sv
package dpd_pkg;

   // Special bytes of the serial framing.
   localparam logic [7:0] BYTE_INTR  = 8'h03;
   localparam logic [7:0] BYTE_START = 8'h24;
   localparam logic [7:0] BYTE_HASH  = 8'h23;
   localparam logic [7:0] BYTE_QUERY = 8'h3F;

   // Result kinds.
   localparam logic [2:0] KIND_PAYLOAD  = 3'd0;
   localparam logic [2:0] KIND_ACCEPT   = 3'd1;
   localparam logic [2:0] KIND_REJECT   = 3'd2;
   localparam logic [2:0] KIND_OVERFLOW = 3'd3;
   localparam logic [2:0] KIND_ABORT    = 3'd4;

   // Acknowledge codes.
   localparam logic [1:0] REPLY_NONE = 2'd0;
   localparam logic [1:0] REPLY_ACK  = 2'd1;
   localparam logic [1:0] REPLY_NAK  = 2'd2;

   // Depth of the queue between front and back end.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // Events that the front end hands to the back end.
   typedef enum logic [2:0] {
      EV_PAYLOAD    = 3'd0,
      EV_ACCEPT     = 3'd1,
      EV_REJECT     = 3'd2,
      EV_OVERFLOW   = 3'd3,
      EV_INTR_IDLE  = 3'd4,
      EV_INTR_FRAME = 3'd5
   } dpd_event_type;

   typedef struct packed {
      dpd_event_type ev;
      logic [7:0]    data;
   } dpd_entry_type;

   // Receiver modes, one-hot.
   typedef enum logic [3:0] {
      MODE_IDLE     = 4'b0001,
      MODE_PAYLOAD  = 4'b0010,
      MODE_DIGIT_HI = 4'b0100,
      MODE_DIGIT_LO = 4'b1000
   } dpd_mode_type;

   // Hex digit decode: bit 4 flags a byte that is not a hex digit.
   function automatic logic [4:0] hex_value(input logic [7:0] b);
      logic [4:0] v;
      v = 5'h10;
      if (b >= 8'h30 && b <= 8'h39) begin
         v = {1'b0, 4'(b - 8'h30)};
      end else if (b >= 8'h61 && b <= 8'h66) begin
         v = {1'b0, 4'(b - 8'h61 + 8'd10)};
      end else if (b >= 8'h41 && b <= 8'h46) begin
         v = {1'b0, 4'(b - 8'h41 + 8'd10)};
      end
      return v;
   endfunction

endpackage

FILE: sv/dpd_if.sv
// Input channel: one received serial byte per beat.
interface dpd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

// Result channel: one result item per beat.
interface dpd_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] kind;
   logic [7:0] data;
   logic [1:0] reply;
   logic       last;

   modport source (output valid, output kind, output data, output reply, output last,
                   input ready);
   modport sink   (input valid, input kind, input data, input reply, input last,
                   output ready);
endinterface

FILE: sv/dpd_front.sv
`include "debug_packet_deframer_unit_defines.svh"

module dpd_front #(
   parameter int MAX_FRAME = 400
) (
   input  logic                   clock,
   input  logic                   reset,
   dpd_req_if.sink                req,
   input  logic                   q_full,
   output logic                   push,
   output dpd_pkg::dpd_entry_type push_entry
);
   import dpd_pkg::*;

   localparam int CNT_W = $clog2(MAX_FRAME);
   localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_FRAME - 1);

   dpd_mode_type     mode_ff, mode_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [7:0]       sum_ff, sum_in;
   logic [3:0]       hi_ff, hi_in;
   logic             hi_bad_ff, hi_bad_in;

   logic             accept;
   logic [7:0]       b;
   logic [4:0]       hv;
   logic             go_idle;

   // A byte is taken whenever the queue has room.
   assign req.ready = !q_full;
   assign accept    = req.valid && !q_full;
   assign b         = req.rx_byte;
   assign hv        = hex_value(b);

   // Classify the byte and update the frame state.
   always_comb begin
      mode_in    = mode_ff;
      count_in   = count_ff;
      sum_in     = sum_ff;
      hi_in      = hi_ff;
      hi_bad_in  = hi_bad_ff;
      go_idle    = 1'b0;
      push       = 1'b0;
      push_entry = '{ev: EV_PAYLOAD, data: 8'h00};

      if (accept) begin
         if (b == BYTE_INTR) begin
            push          = 1'b1;
            push_entry.ev = (mode_ff == MODE_IDLE) ? EV_INTR_IDLE : EV_INTR_FRAME;
            go_idle       = 1'b1;
         end else if (mode_ff == MODE_IDLE) begin
            if (b == BYTE_START) begin
               mode_in   = MODE_PAYLOAD;
               count_in  = CNT_W'(1);
               sum_in    = 8'h00;
               hi_in     = 4'h0;
               hi_bad_in = 1'b0;
            end
         end else if (count_ff == CNT_LIMIT) begin
            push          = 1'b1;
            push_entry.ev = EV_OVERFLOW;
            go_idle       = 1'b1;
         end else begin
            count_in = count_ff + CNT_W'(1);
            unique case (mode_ff)
               MODE_PAYLOAD: begin
                  if (b == BYTE_HASH) begin
                     mode_in = MODE_DIGIT_HI;
                  end else begin
                     sum_in     = sum_ff + b;
                     push       = 1'b1;
                     push_entry = '{ev: EV_PAYLOAD, data: b};
                  end
               end
               MODE_DIGIT_HI: begin
                  hi_in     = hv[3:0];
                  hi_bad_in = hv[4];
                  mode_in   = MODE_DIGIT_LO;
               end
               MODE_DIGIT_LO: begin
                  push = 1'b1;
                  if (!hi_bad_ff && !hv[4] && ({hi_ff, hv[3:0]} == sum_ff)) begin
                     push_entry.ev = EV_ACCEPT;
                  end else begin
                     push_entry.ev = EV_REJECT;
                  end
                  go_idle = 1'b1;
               end
               default: begin
                  go_idle = 1'b1;
               end
            endcase
         end
      end

      if (go_idle) begin
         mode_in   = MODE_IDLE;
         count_in  = '0;
         sum_in    = 8'h00;
         hi_in     = 4'h0;
         hi_bad_in = 1'b0;
      end
   end

   // Frame state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         count_ff  <= '0;
         sum_ff    <= 8'h00;
         hi_ff     <= 4'h0;
         hi_bad_ff <= 1'b0;
      end else begin
         mode_ff   <= mode_in;
         count_ff  <= count_in;
         sum_ff    <= sum_in;
         hi_ff     <= hi_in;
         hi_bad_ff <= hi_bad_in;
      end
   end

   // The frame length never passes the limit, and idle holds an empty frame.
   `DPD_ASSERT(a_count_limit, clock, reset, count_ff <= CNT_LIMIT, "frame count over limit")
   `DPD_ASSERT(a_idle_empty, clock, reset, (mode_ff == MODE_IDLE) |-> (count_ff == '0 && sum_ff == 8'h00), "idle with frame state")

endmodule

FILE: sv/dpd_queue.sv
`include "debug_packet_deframer_unit_defines.svh"

module dpd_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  dpd_pkg::dpd_entry_type push_entry,
   input  logic                   pop,
   output logic                   full,
   output logic                   head_valid,
   output dpd_pkg::dpd_entry_type head_entry
);
   import dpd_pkg::*;

   dpd_entry_type     slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;

   assign full       = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = slot_ff[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (QPTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   // Neither side may run past the other.
   `DPD_ASSERT_NEVER(a_push_full, clock, reset, push && full, "push into full queue")
   `DPD_ASSERT_NEVER(a_pop_empty, clock, reset, pop && !head_valid, "pop from empty queue")

endmodule

FILE: sv/dpd_back.sv
`include "debug_packet_deframer_unit_defines.svh"

module dpd_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   head_valid,
   input  dpd_pkg::dpd_entry_type head_entry,
   output logic                   pop,
   dpd_rsp_if.source              rsp
);
   import dpd_pkg::*;

   logic       valid_ff, valid_in;
   logic [2:0] kind_ff, kind_in;
   logic [7:0] data_ff, data_in;
   logic [1:0] reply_ff, reply_in;
   logic       last_ff, last_in;

   // Beats of an interrupt entry still to send; query means the '?' beat is next.
   logic       pend_ff, pend_in;
   logic       pend_query_ff, pend_query_in;

   logic       load;

   assign load = !valid_ff || rsp.ready;

   // Pick the next beat: finish an interrupt entry first, then take the queue head.
   always_comb begin
      valid_in      = valid_ff;
      kind_in       = kind_ff;
      data_in       = data_ff;
      reply_in      = reply_ff;
      last_in       = last_ff;
      pend_in       = pend_ff;
      pend_query_in = pend_query_ff;
      pop           = 1'b0;

      if (load) begin
         valid_in = 1'b0;
         data_in  = 8'h00;
         reply_in = REPLY_NONE;
         last_in  = 1'b1;
         if (pend_ff) begin
            valid_in = 1'b1;
            if (pend_query_ff) begin
               kind_in       = KIND_PAYLOAD;
               data_in       = BYTE_QUERY;
               last_in       = 1'b0;
               pend_query_in = 1'b0;
            end else begin
               kind_in = KIND_ACCEPT;
               pend_in = 1'b0;
            end
         end else if (head_valid) begin
            valid_in = 1'b1;
            pop      = 1'b1;
            unique case (head_entry.ev)
               EV_PAYLOAD: begin
                  kind_in = KIND_PAYLOAD;
                  data_in = head_entry.data;
               end
               EV_ACCEPT: begin
                  kind_in  = KIND_ACCEPT;
                  reply_in = REPLY_ACK;
               end
               EV_REJECT: begin
                  kind_in  = KIND_REJECT;
                  reply_in = REPLY_NAK;
               end
               EV_OVERFLOW: begin
                  kind_in  = KIND_OVERFLOW;
                  reply_in = REPLY_NAK;
               end
               EV_INTR_IDLE: begin
                  kind_in       = KIND_PAYLOAD;
                  data_in       = BYTE_QUERY;
                  last_in       = 1'b0;
                  pend_in       = 1'b1;
                  pend_query_in = 1'b0;
               end
               EV_INTR_FRAME: begin
                  kind_in       = KIND_ABORT;
                  last_in       = 1'b0;
                  pend_in       = 1'b1;
                  pend_query_in = 1'b1;
               end
               default: begin
                  valid_in = 1'b0;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= 1'b0;
         pend_ff       <= 1'b0;
         pend_query_ff <= 1'b0;
      end else begin
         valid_ff      <= valid_in;
         pend_ff       <= pend_in;
         pend_query_ff <= pend_query_in;
      end
   end

   // Output payload registers.
   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      data_ff  <= data_in;
      reply_ff <= reply_in;
      last_ff  <= last_in;
   end

   assign rsp.valid = valid_ff;
   assign rsp.kind  = kind_ff;
   assign rsp.data  = data_ff;
   assign rsp.reply = reply_ff;
   assign rsp.last  = last_ff;

   // A beat that is not the last one always has its follow-up pending.
   `DPD_ASSERT(a_not_last_pend, clock, reset, (valid_ff && !last_ff) |-> pend_ff, "lost interrupt beat")

endmodule

FILE: sv/debug_packet_deframer_unit.sv
// Receive side of a debugger serial packet link. Bytes arrive on req_chan, one per beat,
// and the front end takes one byte every clock cycle while its four-entry queue has room.
// Bytes before '$' are ignored; payload bytes come out on rsp_chan one result each, '#'
// and the first checksum digit give nothing, and the second digit gives an accept ('+')
// or reject ('-') result. A frame that outgrows MAX_FRAME - 1 bytes is dropped with '-'.
// Byte 0x03 in any mode gives an abort result (only if a frame was open), then a '?'
// payload result and an unacknowledged accept. The back end sends one result beat per
// cycle from its output register while rsp_chan is ready; a byte's first result passes
// through a queue slot and then that register before it is offered on rsp_chan, and an
// interrupt byte gives the back end two or three result beats to send; the queue absorbs
// that while the front end keeps taking bytes.
module debug_packet_deframer_unit #(
   parameter int MAX_FRAME = 400
) (
   input  logic       clock,
   input  logic       reset,
   dpd_req_if.sink    req_chan,
   dpd_rsp_if.source  rsp_chan
);
   import dpd_pkg::*;

   logic          push;
   dpd_entry_type push_entry;
   logic          pop;
   logic          q_full;
   logic          head_valid;
   dpd_entry_type head_entry;

   dpd_front #(
      .MAX_FRAME (MAX_FRAME)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .q_full     (q_full),
      .push       (push),
      .push_entry (push_entry)
   );

   dpd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (q_full),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   dpd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp        (rsp_chan)
   );

endmodule
